/* src/ple_pkg.sv */
// Package for the positional list engine.
// Holds the store geometry, operation and status codes, and the payload types.
// Used by the stream interface users and the top level; depends on nothing.
package ple_pkg;

  // Store geometry; the field widths of the payload fix the depth at 64.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } ple_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } ple_status_e;

  // One operation request.
  typedef struct packed {
    ple_op_e            operation;
    logic [6:0]         position;
    logic [6:0]         run_length;
    logic signed [31:0] value;
  } ple_in_t;

  // One operation result.
  typedef struct packed {
    ple_status_e        status;
    logic [5:0]         found_index;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
  } ple_out_t;

endpackage

/* src/ple_stream_if.sv */
// Valid/ready stream interface carrying one payload of type T per transaction.
// Used by the positional list engine for its request and result channels.
interface ple_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/positional_list_engine.sv */
// Positional list engine: an ordered list of up to 64 signed 32-bit entries held in one
// synchronous dual-port memory (one write port, one registered read port). Operations are
// handled one at a time. A read fetches one entry through the registered read port. An insert
// moves the entries from the tail down to its position and then writes the value (it writes
// directly when it appends), a delete moves the entries behind the run up over it, and a search
// compares entries from index 0 until the first match or the end of the list; refused
// operations, searches of an empty list and deletes that move nothing go straight to the
// response state. The memory read port moves or compares one entry per cycle. A finished result
// waits in an output register, so the next request is taken while the previous result is still
// pending; the response state holds for every cycle that the previous result is still not taken.
module positional_list_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ple_stream_if.sink            in_i,
  ple_stream_if.source          out_o
);
  import ple_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_SEARCH,
    S_READ,
    S_RDDATA,
    S_RESP
  } state_e;

  state_e             state_q;
  ple_op_e            op_q;
  logic [6:0]         pos_q;
  logic [6:0]         run_q;
  logic signed [31:0] val_q;
  logic [CW-1:0]      cnt_q;
  logic [AW-1:0]      idx_q;
  logic               iss_q;
  logic               pend_q;
  logic [AW-1:0]      pend_addr_q;
  ple_status_e        res_status_q;
  logic [5:0]         res_found_q;
  logic signed [31:0] res_rdval_q;
  logic               out_valid_q;
  ple_out_t           out_q;

  // Memory and its port signals.
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] mem_rdata_q;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_wdata;

  // Request decode against the current count.
  ple_in_t            req;
  logic [7:0]         req_end;
  logic               pos_zero;
  logic               ins_bad;
  logic               rng_bad;
  logic               del_bad;
  logic               ins_tail;
  logic               del_tail;
  logic               hit;
  logic               shift_last;
  logic [AW-1:0]      pos_m1;

  assign req      = in_i.data;
  assign pos_zero = (req.position == 7'd0);
  assign req_end  = {1'b0, req.position} - 8'd1 + {1'b0, req.run_length};
  assign ins_bad  = pos_zero || ({1'b0, req.position} > ({1'b0, cnt_q} + 8'd1));
  assign rng_bad  = pos_zero || (req.position > cnt_q);
  assign del_bad  = rng_bad || (req_end > {1'b0, cnt_q});
  assign ins_tail = ((req.position - 7'd1) == cnt_q);
  assign del_tail = (req_end == {1'b0, cnt_q});
  assign pos_m1   = pos_q[AW-1:0] - AW'(1);
  assign hit      = pend_q && (mem_rdata_q == val_q);

  // Last read of a shift: insert walks down to the position, delete walks up to the end.
  always_comb begin
    if (op_q == OP_INSERT) begin
      shift_last = (idx_q == pos_m1);
    end else begin
      shift_last = ({1'b0, idx_q} == (cnt_q - CW'(1)));
    end
  end

  // Memory port control.
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = idx_q;
    mem_waddr = pend_addr_q;
    mem_wdata = mem_rdata_q;
    case (state_q)
      S_SHIFT: begin
        mem_re = 1'b1;
        mem_we = pend_q;
      end
      S_DRAIN: begin
        mem_we = 1'b1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_m1;
        mem_wdata = val_q;
      end
      S_SEARCH: begin
        mem_re = iss_q && !hit;
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = pos_m1;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Sequencer, count and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      iss_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Outside the response state a taken result simply leaves the output register.
      if (out_o.ready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q        <= req.operation;
            pos_q       <= req.position;
            run_q       <= req.run_length;
            val_q       <= req.value;
            res_found_q <= '0;
            res_rdval_q <= '0;
            pend_q      <= 1'b0;
            case (req.operation)
              OP_INSERT: begin
                if (ins_bad) begin
                  res_status_q <= ST_BAD;
                  state_q      <= S_RESP;
                end else if (cnt_q == CW'(DEPTH)) begin
                  res_status_q <= ST_FULL;
                  state_q      <= S_RESP;
                end else if (ins_tail) begin
                  res_status_q <= ST_OK;
                  state_q      <= S_PUT;
                end else begin
                  res_status_q <= ST_OK;
                  idx_q        <= cnt_q[AW-1:0] - AW'(1);
                  state_q      <= S_SHIFT;
                end
              end
              OP_DELETE: begin
                if (del_bad) begin
                  res_status_q <= ST_BAD;
                  state_q      <= S_RESP;
                end else if (req.run_length == 7'd0) begin
                  res_status_q <= ST_OK;
                  state_q      <= S_RESP;
                end else if (del_tail) begin
                  res_status_q <= ST_OK;
                  cnt_q        <= cnt_q - req.run_length;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= ST_OK;
                  idx_q        <= req_end[AW-1:0];
                  state_q      <= S_SHIFT;
                end
              end
              OP_SEARCH: begin
                if (cnt_q == '0) begin
                  res_status_q <= ST_MISSING;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= ST_OK;
                  idx_q        <= '0;
                  iss_q        <= 1'b1;
                  state_q      <= S_SEARCH;
                end
              end
              default: begin
                if (rng_bad) begin
                  res_status_q <= ST_BAD;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= ST_OK;
                  state_q      <= S_READ;
                end
              end
            endcase
          end
        end
        // One entry read and one entry written back per cycle.
        S_SHIFT: begin
          pend_q <= 1'b1;
          if (op_q == OP_INSERT) begin
            pend_addr_q <= idx_q + AW'(1);
            idx_q       <= idx_q - AW'(1);
          end else begin
            pend_addr_q <= idx_q - run_q[AW-1:0];
            idx_q       <= idx_q + AW'(1);
          end
          if (shift_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pend_q <= 1'b0;
          if (op_q == OP_INSERT) begin
            state_q <= S_PUT;
          end else begin
            cnt_q   <= cnt_q - run_q;
            state_q <= S_RESP;
          end
        end
        S_PUT: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= S_RESP;
        end
        // Reads run one ahead of the compare.
        S_SEARCH: begin
          if (hit) begin
            pend_q      <= 1'b0;
            iss_q       <= 1'b0;
            res_found_q <= 6'(pend_addr_q);
            state_q     <= S_RESP;
          end else if (iss_q) begin
            pend_q      <= 1'b1;
            pend_addr_q <= idx_q;
            if ({1'b0, idx_q} == (cnt_q - CW'(1))) begin
              iss_q <= 1'b0;
            end else begin
              idx_q <= idx_q + AW'(1);
            end
          end else begin
            pend_q       <= 1'b0;
            res_status_q <= ST_MISSING;
            state_q      <= S_RESP;
          end
        end
        S_READ: begin
          state_q <= S_RDDATA;
        end
        S_RDDATA: begin
          res_rdval_q <= mem_rdata_q;
          state_q     <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_o.ready) begin
            out_q.status      <= res_status_q;
            out_q.found_index <= res_found_q;
            out_q.read_value  <= res_rdval_q;
            out_q.entry_count <= cnt_q;
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The two memory ports never touch the same entry in one cycle.
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("memory read and write to the same entry");

  // The count never exceeds the store depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // A new result is only loaded from the response state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result loaded outside response state");

  // No write-back is left pending when a new transaction is taken.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("pending write-back while idle");

  // Searches and reads never change the count.
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SEARCH) || (state_q == S_READ) || (state_q == S_RDDATA)) |=> $stable(cnt_q))
    else $error("count changed by a search or read");
`endif

endmodule

/* tb/sv/ple_list_checker.sv */
`timescale 1ns / 100ps
// Result checker for the positional list engine: watches the request and result channels,
// keeps a shadow copy of the list and compares every result with its prediction.
// Depends on ple_pkg for the payload types and the operation and status codes.
module ple_list_checker
  import ple_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic       req_ready_i,
  input  ple_in_t    req_data_i,
  input  logic       rsp_valid_i,
  input  logic       rsp_ready_i,
  input  ple_out_t   rsp_data_i,
  output int         mismatch_count_o,
  output int         pending_o,
  output logic [6:0] entry_count_o
);

  // Shadow of the stored list, index 0 is list position 1.
  logic signed [31:0] shadow_list[$];
  // Predicted results still waiting for their transaction on the result channel.
  ple_out_t           pending_results[$];
  ple_out_t           want;
  int                 fail_cnt;

  // Applies one operation to the shadow list and returns the result it should produce.
  function automatic ple_out_t apply_list_op(input ple_in_t req);
    ple_out_t    res;
    int unsigned cnt;
    int unsigned pos;
    int unsigned run;
    int unsigned i;
    bit          hit;
    res = '0;
    res.status = ST_OK;
    cnt = shadow_list.size();
    pos = req.position;
    run = req.run_length;
    hit = 1'b0;
    case (req.operation)
      OP_INSERT: begin
        if (pos < 1 || pos > cnt + 1) begin
          res.status = ST_BAD;
        end else if (cnt >= DEPTH) begin
          // The position is checked before the store is found full.
          res.status = ST_FULL;
        end else begin
          shadow_list.insert(pos - 1, req.value);
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > cnt || pos - 1 + run > cnt) begin
          res.status = ST_BAD;
        end else begin
          repeat (run) shadow_list.delete(pos - 1);
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < cnt; i++) begin
          if (!hit && shadow_list[i] == req.value) begin
            hit = 1'b1;
            res.found_index = 6'(i);
          end
        end
        if (!hit) res.status = ST_MISSING;
      end
      default: begin
        if (pos < 1 || pos > cnt) res.status = ST_BAD;
        else res.read_value = shadow_list[pos - 1];
      end
    endcase
    res.entry_count = 7'(shadow_list.size());
    return res;
  endfunction

  // Predict on every request transaction, compare on every result transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_list.delete();
      pending_results.delete();
      fail_cnt = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
      entry_count_o <= '0;
    end else begin
      if (req_valid_i && req_ready_i) begin
        pending_results.push_back(apply_list_op(req_data_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_results.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("%0t: result with no request outstanding: status=%s count=%0d",
                     $time, rsp_data_i.status.name(), rsp_data_i.entry_count);
          end
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (want !== rsp_data_i) begin
            if (fail_cnt < 10) begin
              $display("%0t: mismatch: expected status=%s index=%0d read=%0d count=%0d",
                       $time, want.status.name(), want.found_index, want.read_value,
                       want.entry_count);
              $display("%0t:           got      status=%s index=%0d read=%0d count=%0d",
                       $time, rsp_data_i.status.name(), rsp_data_i.found_index,
                       rsp_data_i.read_value, rsp_data_i.entry_count);
            end
            fail_cnt++;
          end
        end
      end
      // Outputs move on the clock so the stimulus side always sees settled values.
      mismatch_count_o <= fail_cnt;
      pending_o <= pending_results.size();
      entry_count_o <= 7'(shadow_list.size());
    end
  end

endmodule

/* tb/sv/tb_positional_list_engine.sv */
`timescale 1ns / 100ps
// Top of the positional list engine testbench: clock, reset, request stimulus and result
// back-pressure, with the verdict taken from ple_list_checker.
// Depends on ple_pkg, ple_stream_if, positional_list_engine and ple_list_checker.
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int RAND_OPS     = 1600;
  localparam int PHASE_LEN    = 160;
  localparam int DRAIN_CYCLES = 80;
  // The limit sits well above a run in which every operation walks the full list and every
  // request is followed by the longest gap.
  localparam int CYCLE_LIMIT  = 2_000_000;

  // Operation mixes of the random phases.
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_MIXED  = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          idle_pct;
  int          stall_pct;
  int unsigned cycle_cnt = 0;
  int          mismatch_count;
  int          pending;
  logic [6:0]  list_count;

  ple_stream_if #(.T(ple_in_t))  req_if ();
  ple_stream_if #(.T(ple_out_t)) rsp_if ();

  positional_list_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  ple_list_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_if.valid),
    .req_ready_i      (req_if.ready),
    .req_data_i       (req_if.data),
    .rsp_valid_i      (rsp_if.valid),
    .rsp_ready_i      (rsp_if.ready),
    .rsp_data_i       (rsp_if.data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .entry_count_o    (list_count)
  );

  always #4 clk_i = ~clk_i;

  // Result channel back-pressure, redrawn every cycle and held low during reset.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sends one request transaction, then leaves a random gap on the channel.
  task automatic issue_op(input ple_op_e op, input int unsigned pos, input int unsigned run,
                          input logic [31:0] val);
    ple_in_t     req;
    int unsigned gap;
    req.operation = op;
    req.position = 7'(pos);
    req.run_length = 7'(run);
    req.value = val;
    gap = 0;
    req_if.valid <= 1'b1;
    req_if.data <= req;
    do @(posedge clk_i); while (!req_if.ready);
    while ($urandom_range(99) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Values come mostly from a small set so that searches hit and duplicates occur.
  function automatic logic [31:0] pick_value();
    logic [31:0] pool[8];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_002A, 32'h5555_5555};
    if ($urandom_range(99) < 70) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // One random phase; most requests are well formed against the current list length.
  task automatic run_phase(input int mix, input int n_ops);
    int unsigned cnt;
    int unsigned roll;
    int unsigned pos;
    int unsigned run;
    int unsigned span;
    int          w_ins;
    int          w_del;
    int          w_srch;
    ple_op_e     op;
    case (mix)
      MIX_GROW:   begin w_ins = 80; w_del = 3;  w_srch = 10; end
      MIX_SHRINK: begin w_ins = 20; w_del = 50; w_srch = 15; end
      default:    begin w_ins = 35; w_del = 25; w_srch = 20; end
    endcase
    repeat (n_ops) begin
      cnt = list_count;
      if ($urandom_range(99) < 10) begin
        // Noise: any field value at all.
        op = ple_op_e'($urandom_range(3));
        issue_op(op, $urandom_range(127), $urandom_range(127), $urandom);
      end else begin
        roll = $urandom_range(99);
        if (roll < w_ins) begin
          issue_op(OP_INSERT, $urandom_range(cnt + 1, 1), $urandom_range(127), pick_value());
        end else if (roll < w_ins + w_del) begin
          pos = (cnt == 0) ? 1 : $urandom_range(cnt, 1);
          span = (cnt >= pos) ? cnt - pos + 1 : 0;
          case ($urandom_range(3))
            0, 1:    run = (span > 0) ? 1 : 0;
            2:       run = $urandom_range(span, 0);
            default: run = span;
          endcase
          issue_op(OP_DELETE, pos, run, $urandom);
        end else if (roll < w_ins + w_del + w_srch) begin
          issue_op(OP_SEARCH, $urandom_range(127), $urandom_range(127), pick_value());
        end else begin
          issue_op(OP_READ, $urandom_range(cnt, 1), $urandom_range(127), $urandom);
        end
      end
    end
  endtask

  initial begin
    int ph;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: refusals on the empty list, field extremes, first match, delete edge cases.
    issue_op(OP_READ,   1,   0,   32'h0000_0000);
    issue_op(OP_SEARCH, 0,   0,   32'h0000_0000);
    issue_op(OP_DELETE, 1,   0,   32'h0000_0000);
    issue_op(OP_INSERT, 0,   0,   32'h0000_0011);
    issue_op(OP_INSERT, 2,   0,   32'h0000_0012);
    issue_op(OP_INSERT, 1,   0,   32'h8000_0000);
    issue_op(OP_INSERT, 2,   127, 32'h7FFF_FFFF);
    issue_op(OP_INSERT, 1,   0,   32'h0000_0000);
    issue_op(OP_INSERT, 127, 0,   32'hFFFF_FFFF);
    issue_op(OP_READ,   0,   0,   32'h0000_0000);
    issue_op(OP_READ,   127, 127, 32'hFFFF_FFFF);
    issue_op(OP_READ,   3,   0,   32'h0000_0000);
    issue_op(OP_READ,   1,   0,   32'h0000_0000);
    issue_op(OP_SEARCH, 0,   0,   32'h7FFF_FFFF);
    issue_op(OP_SEARCH, 0,   0,   32'hFFFF_FFFF);
    issue_op(OP_INSERT, 2,   0,   32'h0000_0000);
    issue_op(OP_SEARCH, 127, 127, 32'h0000_0000);
    issue_op(OP_DELETE, 2,   0,   32'h0000_0000);
    issue_op(OP_DELETE, 2,   4,   32'h0000_0000);
    issue_op(OP_DELETE, 1,   127, 32'h0000_0000);
    issue_op(OP_DELETE, 5,   0,   32'h0000_0000);
    issue_op(OP_DELETE, 2,   3,   32'h0000_0000);
    issue_op(OP_DELETE, 1,   1,   32'h0000_0000);
    issue_op(OP_SEARCH, 0,   0,   32'h0000_0000);

    // Random phases: the operation mix and the idling pattern change from phase to phase.
    for (ph = 0; ph < RAND_OPS / PHASE_LEN; ph++) begin
      case (ph % 4)
        0: begin idle_pct <= 0;  stall_pct <= 0;  end
        1: begin idle_pct <= 86; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 86; end
        default: begin idle_pct <= 7; stall_pct <= 7; end
      endcase
      run_phase(ph % 3, PHASE_LEN);
    end
    req_if.valid <= 1'b0;
    stall_pct <= 0;

    // Let the last transaction reach the checker, then drain outstanding results.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ple_pkg.sv
src/ple_stream_if.sv
src/positional_list_engine.sv
tb/sv/ple_list_checker.sv
tb/sv/tb_positional_list_engine.sv
